// ===== sv/ftfp_pkg.sv =====
// Shared types and constants of the fixed-timestep frame pacer.
// Used by the configuration bank, the arithmetic unit and the top level.
package ftfp_pkg;

  // Number of vsync period slots and how many of them are checked.
  localparam int unsigned SnapSlots = 5;
  localparam int unsigned SnapCount = 5;

  // A frame delta above this many frame periods counts as a stall.
  localparam int unsigned SlowFrames = 8;

  // Largest number of updates that one frame can release.
  localparam logic [3:0] MaxDue = 4'd8;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FRAME_PERIOD   = 3'd0;
  localparam logic [2:0] CFG_SNAP_TOLERANCE = 3'd1;
  localparam logic [2:0] CFG_SNAP_PERIOD_A  = 3'd2;
  localparam logic [2:0] CFG_SNAP_PERIOD_B  = 3'd3;
  localparam logic [2:0] CFG_SNAP_PERIOD_C  = 3'd4;
  localparam logic [2:0] CFG_SNAP_PERIOD_D  = 3'd5;
  localparam logic [2:0] CFG_SNAP_PERIOD_E  = 3'd6;
  localparam logic [2:0] CFG_BATCH_SIZE     = 3'd7;

  // Operation codes of the shared add/subtract unit.
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  // Current configuration as seen by the sequencer.
  typedef struct packed {
    logic [15:0]                frame_period;
    logic [15:0]                snap_tolerance;
    logic [SnapSlots-1:0][15:0] snap_period;
    logic [3:0]                 batch_size;
  } cfg_t;

  // Request to the shared arithmetic unit.
  typedef struct packed {
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // Answer of the shared arithmetic unit. For a subtract, borrow means a < b;
  // for an add it is the carry out.
  typedef struct packed {
    logic [31:0] res;
    logic        borrow;
  } alu_rsp_t;

endpackage

// ===== sv/ftfp_cfg.sv =====
// Configuration register bank of the frame pacer.
// Depends on ftfp_pkg for the register indexes and the cfg_t struct.
module ftfp_cfg import ftfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  // One register is written per enabled beat; there is no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_period   <= 16'd16;
      cfg_q.snap_tolerance <= 16'd0;
      cfg_q.snap_period[0] <= 16'd66;
      cfg_q.snap_period[1] <= 16'd33;
      cfg_q.snap_period[2] <= 16'd16;
      cfg_q.snap_period[3] <= 16'd8;
      cfg_q.snap_period[4] <= 16'd4;
      cfg_q.batch_size     <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_PERIOD:   cfg_q.frame_period   <= cfg_data_i;
        CFG_SNAP_TOLERANCE: cfg_q.snap_tolerance <= cfg_data_i;
        CFG_SNAP_PERIOD_A:  cfg_q.snap_period[0] <= cfg_data_i;
        CFG_SNAP_PERIOD_B:  cfg_q.snap_period[1] <= cfg_data_i;
        CFG_SNAP_PERIOD_C:  cfg_q.snap_period[2] <= cfg_data_i;
        CFG_SNAP_PERIOD_D:  cfg_q.snap_period[3] <= cfg_data_i;
        CFG_SNAP_PERIOD_E:  cfg_q.snap_period[4] <= cfg_data_i;
        CFG_BATCH_SIZE:     cfg_q.batch_size     <= cfg_data_i[3:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ftfp_alu.sv =====
// Shared 32-bit add/subtract unit with carry or borrow out.
// Depends on ftfp_pkg for the request and answer structs.
module ftfp_alu import ftfp_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [31:0] b_op;
  logic [32:0] sum;

  // A subtract adds the inverted operand plus one; the carry then means no borrow.
  always_comb begin
    b_op = (req_i.op == ALU_SUB) ? ~req_i.b : req_i.b;
    sum  = {1'b0, req_i.a} + {1'b0, b_op} + {32'd0, (req_i.op == ALU_SUB)};
    rsp_o.res    = sum[31:0];
    rsp_o.borrow = (req_i.op == ALU_SUB) ? ~sum[32] : sum[32];
  end

endmodule

// ===== sv/fixed_timestep_frame_pacer.sv =====
// Top level of the fixed-timestep frame pacer: sequencer, state and output register.
// Depends on ftfp_pkg, ftfp_cfg and ftfp_alu.
//
// One timestamp beat yields one result beat. The arithmetic steps run
// through a single shared 32-bit add/subtract unit under a small sequencer
// (the batch step product and the due count are formed apart): delta and
// stall clamp, each vsync candidate in one or two subtracts and a tolerance
// compare, accumulate and reset check, one loop pass per released batch plus
// one final compare, then the running total and the output load. How long an
// item occupies the block after acceptance is set mostly by the snap search
// and the batch loop, plus any wait for the output register to be emptied.
// The input is not ready during that time; a finished result sits in an
// output register, so the next timestamp can be taken while the previous
// result waits to be collected.
module fixed_timestep_frame_pacer import ftfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] timestamp_i,
  input  logic        reset_request_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [18:0] delta_used_o,
  output logic [3:0]  updates_due_o,
  output logic [31:0] update_total_o,
  output logic        was_snapped_o,
  output logic        was_reset_o
);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_LIM  = 4'd2;
  localparam logic [3:0] S_SUB  = 4'd3;
  localparam logic [3:0] S_NEG  = 4'd4;
  localparam logic [3:0] S_TOL  = 4'd5;
  localparam logic [3:0] S_ADD  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_BAT  = 4'd8;
  localparam logic [3:0] S_TOT  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  localparam logic [2:0] LastSnap = 3'(SnapCount - 1);

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [3:0]  state_q, state_d;
  logic [31:0] now_q, now_d;
  logic        req_q, req_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] delta_q, delta_d;
  logic [31:0] absdiff_q, absdiff_d;
  logic [2:0]  idx_q, idx_d;
  logic        snapped_q, snapped_d;
  logic        cleared_q, cleared_d;
  logic        pending_q, pending_d;
  logic [21:0] acc_q, acc_d;
  logic [19:0] step_q, step_d;
  logic [3:0]  due_q, due_d;
  logic [31:0] issued_q, issued_d;
  logic        out_valid_q, out_valid_d;
  logic [18:0] out_delta_q;
  logic [3:0]  out_due_q;
  logic [31:0] out_total_q;
  logic        out_snapped_q;
  logic        out_reset_q;

  logic [3:0]  batch_n;
  logic [18:0] limit;
  logic [15:0] snap_p;
  logic        in_beat;
  logic        out_load;

  ftfp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ftfp_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Derived configuration values: a batch size of zero acts as one.
  assign batch_n = (cfg.batch_size == 4'd0) ? 4'd1 : cfg.batch_size;
  assign limit   = {cfg.frame_period, 3'b000};
  assign snap_p  = cfg.snap_period[idx_q];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // Operand selection for the shared unit.
  always_comb begin
    alu_req = '{op: ALU_SUB, a: 32'd0, b: 32'd0};
    unique case (state_q)
      S_DIFF:  alu_req = '{op: ALU_SUB, a: now_q, b: prev_q};
      S_LIM:   alu_req = '{op: ALU_SUB, a: {13'd0, limit}, b: delta_q};
      S_SUB:   alu_req = '{op: ALU_SUB, a: delta_q, b: {16'd0, snap_p}};
      S_NEG:   alu_req = '{op: ALU_SUB, a: {16'd0, snap_p}, b: delta_q};
      S_TOL:   alu_req = '{op: ALU_SUB, a: {16'd0, cfg.snap_tolerance}, b: absdiff_q};
      S_ADD:   alu_req = '{op: ALU_ADD, a: {10'd0, acc_q}, b: delta_q};
      S_CHK:   alu_req = '{op: ALU_SUB, a: {13'd0, limit}, b: {10'd0, acc_q}};
      S_BAT:   alu_req = '{op: ALU_SUB, a: {10'd0, acc_q}, b: {12'd0, step_q}};
      S_TOT:   alu_req = '{op: ALU_ADD, a: issued_q, b: {28'd0, due_q}};
      default: alu_req = '{op: ALU_SUB, a: 32'd0, b: 32'd0};
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    req_d       = req_q;
    prev_d      = prev_q;
    delta_d     = delta_q;
    absdiff_d   = absdiff_q;
    idx_d       = idx_q;
    snapped_d   = snapped_q;
    cleared_d   = cleared_q;
    pending_d   = pending_q;
    acc_d       = acc_q;
    step_d      = step_q;
    due_d       = due_q;
    issued_d    = issued_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          now_d     = timestamp_i;
          req_d     = reset_request_i;
          step_d    = {4'd0, cfg.frame_period} * {16'd0, batch_n};
          snapped_d = 1'b0;
          cleared_d = 1'b0;
          state_d   = S_DIFF;
        end
      end
      // A clock that did not advance gives one frame period.
      S_DIFF: begin
        if (!alu_rsp.borrow && (alu_rsp.res != 32'd0)) begin
          delta_d = alu_rsp.res;
        end else begin
          delta_d = {16'd0, cfg.frame_period};
        end
        prev_d  = now_q;
        state_d = S_LIM;
      end
      // A delta longer than eight periods is a stall and is replaced.
      S_LIM: begin
        if (alu_rsp.borrow) begin
          delta_d = {16'd0, cfg.frame_period};
        end
        idx_d   = 3'd0;
        state_d = S_SUB;
      end
      // Absolute distance to the current candidate, in one or two subtracts.
      S_SUB: begin
        if (alu_rsp.borrow) begin
          state_d = S_NEG;
        end else begin
          absdiff_d = alu_rsp.res;
          state_d   = S_TOL;
        end
      end
      S_NEG: begin
        absdiff_d = alu_rsp.res;
        state_d   = S_TOL;
      end
      // The first candidate within tolerance wins.
      S_TOL: begin
        if (!alu_rsp.borrow) begin
          delta_d   = {16'd0, snap_p};
          snapped_d = 1'b1;
          state_d   = S_ADD;
        end else if (idx_q == LastSnap) begin
          state_d = S_ADD;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_SUB;
        end
      end
      S_ADD: begin
        acc_d   = alu_rsp.res[21:0];
        state_d = S_CHK;
      end
      // Pending, requested or overflow reset clears the accumulator.
      S_CHK: begin
        if (pending_q || req_q || alu_rsp.borrow) begin
          acc_d     = 22'd0;
          delta_d   = {16'd0, cfg.frame_period};
          snapped_d = 1'b0;
          cleared_d = 1'b1;
          pending_d = 1'b0;
        end
        due_d   = 4'd0;
        state_d = (cfg.frame_period != 16'd0) ? S_BAT : S_TOT;
      end
      // Release one whole batch per cycle while it fits.
      S_BAT: begin
        if (!alu_rsp.borrow) begin
          acc_d = alu_rsp.res[21:0];
          due_d = due_q + batch_n;
        end else begin
          state_d = S_TOT;
        end
      end
      S_TOT: begin
        issued_d = alu_rsp.res;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= 32'd0;
      acc_q       <= 22'd0;
      pending_q   <= 1'b1;
      issued_q    <= 32'd0;
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
      due_q       <= 4'd0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      acc_q       <= acc_d;
      pending_q   <= pending_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      due_q       <= due_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    req_q     <= req_d;
    delta_q   <= delta_d;
    absdiff_q <= absdiff_d;
    snapped_q <= snapped_d;
    cleared_q <= cleared_d;
    step_q    <= step_d;
  end

  // Output register holds a finished result until its beat is taken.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_delta_q   <= delta_q[18:0];
      out_due_q     <= due_q;
      out_total_q   <= issued_q;
      out_snapped_q <= snapped_q;
      out_reset_q   <= cleared_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign delta_used_o   = out_delta_q;
  assign updates_due_o  = out_due_q;
  assign update_total_o = out_total_q;
  assign was_snapped_o  = out_snapped_q;
  assign was_reset_o    = out_reset_q;

  // A frame never releases more than eight updates.
  assert property (@(posedge clk_i) disable iff (!rst_ni) due_q <= MaxDue)
    else $error("updates due exceed eight");

  // During the batch loop the accumulator stays within eight frame periods.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BAT) |-> (acc_q <= {3'b000, limit}))
    else $error("accumulator above eight periods in batch loop");

  // Loading the output register presents a result and frees the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("finished result not presented");

  // No update is counted before the first reset has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (issued_q == 32'd0))
    else $error("updates counted before the initial reset");

endmodule

// ===== sim/tb_fixed_timestep_frame_pacer.sv =====
// Self-checking testbench of the fixed-timestep frame pacer.
// Depends on ftfp_pkg and fixed_timestep_frame_pacer; a built-in predictor
// checks every result beat against the frame timestamps that were sent.
module tb_fixed_timestep_frame_pacer;
  import ftfp_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReport   = 10;

  // One timestamp beat and one result beat.
  typedef struct packed {
    logic [31:0] stamp;
    logic        req;
  } frame_in_t;

  typedef struct packed {
    logic [18:0] delta;
    logic [3:0]  due;
    logic [31:0] total;
    logic        snapped;
    logic        cleared;
  } frame_out_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_idx_i       = CFG_FRAME_PERIOD;
  logic [15:0] cfg_data_i      = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [31:0] timestamp_i     = '0;
  logic        reset_request_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [18:0] delta_used_o;
  logic [3:0]  updates_due_o;
  logic [31:0] update_total_o;
  logic        was_snapped_o;
  logic        was_reset_o;

  fixed_timestep_frame_pacer dut (.*);

  // Shadow copy of the pacer configuration and state.
  cfg_t        pacer_cfg;
  logic [31:0] last_stamp;
  logic [31:0] accum;
  logic [31:0] issued;
  logic        reset_pending;

  frame_in_t   frame_q[$];
  frame_out_t  expected_frames[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  logic [31:0] gen_now     = '0;

  int unsigned send_gap    = 0;
  logic        send_burst  = 1'b0;
  int unsigned recv_stall  = 0;
  logic        recv_burst  = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Register values and state right after reset.
  function automatic void reset_pacer_model();
    pacer_cfg.frame_period   = 16'd16;
    pacer_cfg.snap_tolerance = 16'd0;
    pacer_cfg.snap_period[0] = 16'd66;
    pacer_cfg.snap_period[1] = 16'd33;
    pacer_cfg.snap_period[2] = 16'd16;
    pacer_cfg.snap_period[3] = 16'd8;
    pacer_cfg.snap_period[4] = 16'd4;
    pacer_cfg.batch_size     = 4'd1;
    last_stamp    = '0;
    accum         = '0;
    issued        = '0;
    reset_pending = 1'b1;
  endfunction

  // Works out the result of one frame and advances the shadow state.
  function automatic frame_out_t predict_frame(logic [31:0] now, logic req);
    logic [31:0] fp;
    logic [31:0] limit;
    logic [31:0] delta;
    logic [31:0] cand;
    logic [31:0] diff;
    logic [31:0] bsize;
    logic [31:0] due;
    logic        snapped;
    logic        cleared;
    int          i;
    frame_out_t  r;
    fp      = {16'd0, pacer_cfg.frame_period};
    limit   = fp * SlowFrames;
    snapped = 1'b0;
    cleared = 1'b0;
    due     = '0;
    delta   = (now > last_stamp) ? now - last_stamp : fp;
    if (delta > limit) delta = fp;
    last_stamp = now;
    // First vsync candidate within tolerance wins.
    for (i = 0; i < SnapCount; i++) begin
      cand = {16'd0, pacer_cfg.snap_period[i]};
      diff = (delta >= cand) ? delta - cand : cand - delta;
      if (!snapped && diff <= {16'd0, pacer_cfg.snap_tolerance}) begin
        delta   = cand;
        snapped = 1'b1;
      end
    end
    accum = (accum + delta) & 32'h003F_FFFF;
    if (reset_pending || req || accum > limit) begin
      accum         = '0;
      delta         = fp;
      snapped       = 1'b0;
      cleared       = 1'b1;
      reset_pending = 1'b0;
    end
    // Release whole batches of updates.
    bsize = (pacer_cfg.batch_size == 4'd0) ? 32'd1 : {28'd0, pacer_cfg.batch_size};
    if (fp != 0) begin
      due   = (accum / (fp * bsize)) * bsize;
      accum = accum - due * fp;
    end
    issued    = issued + due;
    r.delta   = delta[18:0];
    r.due     = due[3:0];
    r.total   = issued;
    r.snapped = snapped;
    r.cleared = cleared;
    return r;
  endfunction

  function automatic void push_frame(logic [31:0] stamp, logic req);
    frame_in_t f;
    f.stamp = stamp;
    f.req   = req;
    frame_q.push_back(f);
  endfunction

  // Mostly plausible frame intervals near the frame period and the vsync
  // candidates, with stalls, long pauses, wraps and jumps mixed in.
  function automatic void push_random(int unsigned n);
    int unsigned k;
    int unsigned sel;
    int unsigned base;
    int unsigned jit;
    int unsigned span;
    int unsigned fp;
    for (k = 0; k < n; k++) begin
      fp   = 32'(pacer_cfg.frame_period);
      span = (pacer_cfg.snap_tolerance > 64) ? 66 : pacer_cfg.snap_tolerance + 2;
      sel  = $urandom_range(0, 99);
      if (sel < 45) base = 32'(pacer_cfg.snap_period[$urandom_range(0, SnapSlots - 1)]);
      else if (sel < 75) base = fp * $urandom_range(1, 3);
      else if (sel < 82) base = 0;
      else if (sel < 88) base = fp * SlowFrames + $urandom_range(1, 1000);
      else base = $urandom;
      jit = (sel < 75) ? $urandom_range(0, span) : 0;
      if ($urandom_range(0, 1) == 1) base = base + jit;
      else if (base >= jit) base = base - jit;
      if (sel >= 94) gen_now = $urandom;
      else gen_now = gen_now + base;
      push_frame(gen_now, $urandom_range(0, 19) == 0);
    end
  endfunction

  function automatic cfg_t random_config();
    cfg_t        c;
    int          i;
    int unsigned fp;
    case ($urandom_range(0, 3))
      0, 1:    fp = $urandom_range(1, 40);
      2:       fp = $urandom_range(41, 2000);
      default: fp = $urandom_range(1, 65535);
    endcase
    c.frame_period   = fp[15:0];
    c.snap_tolerance = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    for (i = 0; i < SnapSlots; i++) begin
      if ($urandom_range(0, 4) == 0) c.snap_period[i] = 16'($urandom);
      else c.snap_period[i] = 16'((fp * $urandom_range(1, 8)) >> $urandom_range(0, 2));
    end
    c.batch_size = 4'($urandom_range(1, 8));
    return c;
  endfunction

  // One register write per clock; the shadow copy follows each write.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_FRAME_PERIOD:   pacer_cfg.frame_period = val;
      CFG_SNAP_TOLERANCE: pacer_cfg.snap_tolerance = val;
      CFG_BATCH_SIZE:     pacer_cfg.batch_size = val[3:0];
      default:            pacer_cfg.snap_period[idx - CFG_SNAP_PERIOD_A] = val;
    endcase
  endtask

  task automatic load_config(cfg_t c);
    int i;
    write_reg(CFG_FRAME_PERIOD, c.frame_period);
    write_reg(CFG_SNAP_TOLERANCE, c.snap_tolerance);
    for (i = 0; i < SnapSlots; i++) begin
      write_reg(CFG_SNAP_PERIOD_A + 3'(i), c.snap_period[i]);
    end
    write_reg(CFG_BATCH_SIZE, {12'd0, c.batch_size});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every frame is sent and answered, then lets the block settle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (frame_q.size() != 0 || in_valid_i || expected_frames.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Driver: presents queued frames with a random gap after each beat.
  always @(posedge clk_i) begin
    frame_in_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_frames.push_back(predict_frame(timestamp_i, reset_request_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (frame_q.size() != 0) begin
          nxt = frame_q.pop_front();
          in_valid_i      <= 1'b1;
          timestamp_i     <= nxt.stamp;
          reset_request_i <= nxt.req;
          if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 17);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls at random after it.
  always @(posedge clk_i) begin
    frame_out_t got;
    frame_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {delta_used_o, updates_due_o, update_total_o, was_snapped_o, was_reset_o};
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReport) begin
            $display("unexpected result beat: delta %0d due %0d total %0d snap %0b reset %0b",
                     got.delta, got.due, got.total, got.snapped, got.cleared);
          end
        end else begin
          want = expected_frames.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReport) begin
              $display("result mismatch: delta %0d/%0d due %0d/%0d total %0d/%0d",
                       want.delta, got.delta, want.due, got.due, want.total, got.total);
              $display("  snapped %0b/%0b reset %0b/%0b (expected/actual)",
                       want.snapped, got.snapped, want.cleared, got.cleared);
            end
          end
        end
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 17);
      end
      if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    int   p;
    reset_pacer_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset configuration: the pending reset, every
    // vsync candidate, a stalled clock, the slow-frame limit and just past it,
    // requested resets, a wrapped clock and extreme timestamps.
    push_frame(32'd0, 1'b0);
    push_frame(32'd16, 1'b0);
    push_frame(32'd82, 1'b0);
    push_frame(32'd82, 1'b0);
    push_frame(32'd115, 1'b0);
    push_frame(32'd123, 1'b0);
    push_frame(32'd127, 1'b0);
    push_frame(32'd327, 1'b0);
    push_frame(32'd455, 1'b0);
    push_frame(32'd584, 1'b0);
    push_frame(32'd600, 1'b1);
    push_frame(32'd601, 1'b0);
    push_frame(32'hFFFF_FFFF, 1'b0);
    push_frame(32'h0000_0005, 1'b0);
    push_frame(32'h5555_5555, 1'b0);
    push_frame(32'hAAAA_AAAA, 1'b1);
    push_frame(32'hAAAA_AAB4, 1'b0);
    push_frame(32'hAAAA_AAB4, 1'b1);
    gen_now = 32'hAAAA_AAB4;
    wait_idle();

    // Smallest frame period with the largest batch.
    c.frame_period   = 16'd1;
    c.snap_tolerance = 16'd0;
    c.snap_period[0] = 16'd0;
    c.snap_period[1] = 16'd1;
    c.snap_period[2] = 16'd2;
    c.snap_period[3] = 16'd3;
    c.snap_period[4] = 16'hFFFF;
    c.batch_size     = 4'd8;
    load_config(c);
    push_random(60);
    wait_idle();

    // Largest frame period and tolerance: nearly every delta snaps.
    c.frame_period   = 16'hFFFF;
    c.snap_tolerance = 16'hFFFF;
    c.snap_period[0] = 16'hFFFF;
    c.snap_period[1] = 16'd0;
    c.snap_period[4] = 16'd0;
    c.batch_size     = 4'd8;
    load_config(c);
    push_random(60);
    wait_idle();

    // Zero frame period and zero batch size.
    c.frame_period   = 16'd0;
    c.snap_tolerance = 16'd3;
    c.snap_period[0] = 16'd66;
    c.snap_period[1] = 16'd33;
    c.batch_size     = 4'd0;
    load_config(c);
    push_random(40);
    wait_idle();

    // Batches too large to ever fit.
    c.frame_period   = 16'd100;
    c.snap_tolerance = 16'd2;
    c.batch_size     = 4'd15;
    load_config(c);
    push_random(30);
    wait_idle();
    c.frame_period = 16'd3;
    c.batch_size   = 4'd9;
    load_config(c);
    push_random(30);
    wait_idle();

    // Random settings.
    for (p = 0; p < 12; p++) begin
      load_config(random_config());
      push_random(115);
      wait_idle();
    end

    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
